[src/assert_macros.svh]
// Assertion macros, clocked on the rising edge, disabled while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge.
`define AST_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent at the next edge.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/etvs_pkg.sv]
package etvs_pkg;

	localparam int CMD_W  = 5;
	localparam int TICK_W = 20;
	localparam int TIME_W = 32;
	localparam int NVALVE = 8;
	localparam int NSTEP  = 6;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_IGN   = 3'd1,
		MODE_WATER = 3'd2,
		MODE_HOT   = 3'd3,
		MODE_ABORT = 3'd4,
		MODE_TERM  = 3'd5,
		MODE_REL   = 3'd6
	} mode_t;

	localparam logic [CMD_W-1:0] CMD_VALVE_FIRST = 5'd1;
	localparam logic [CMD_W-1:0] CMD_VALVE_LAST  = 5'd16;
	localparam logic [CMD_W-1:0] CMD_SPARK_ON    = 5'd17;
	localparam logic [CMD_W-1:0] CMD_SPARK_OFF   = 5'd18;
	localparam logic [CMD_W-1:0] CMD_IGN_TEST    = 5'd19;
	localparam logic [CMD_W-1:0] CMD_WATER       = 5'd20;
	localparam logic [CMD_W-1:0] CMD_HOTFIRE     = 5'd21;
	localparam logic [CMD_W-1:0] CMD_STANDBY     = 5'd22;
	localparam logic [CMD_W-1:0] CMD_IDLE        = 5'd23;
	localparam logic [CMD_W-1:0] CMD_ABORT       = 5'd24;
	localparam logic [CMD_W-1:0] CMD_HOT_IDLE    = 5'd25;

	localparam logic [NVALVE-1:0] V_PURGE    = 8'h02;
	localparam logic [NVALVE-1:0] V_MAIN_ETH = 8'h04;
	localparam logic [NVALVE-1:0] V_MAIN_N2O = 8'h08;
	localparam logic [NVALVE-1:0] V_IGN_ETH  = 8'h20;
	localparam logic [NVALVE-1:0] V_IGN_OX   = 8'h40;
	localparam logic [NVALVE-1:0] V_BLEED    = 8'h80;

	// times in microseconds
	localparam logic [TIME_W-1:0] T_0_2 = 32'd200000;
	localparam logic [TIME_W-1:0] T_0_3 = 32'd300000;
	localparam logic [TIME_W-1:0] T_0_5 = 32'd500000;
	localparam logic [TIME_W-1:0] T_0_7 = 32'd700000;
	localparam logic [TIME_W-1:0] T_1_0 = 32'd1000000;
	localparam logic [TIME_W-1:0] T_2_0 = 32'd2000000;
	localparam logic [TIME_W-1:0] T_2_3 = 32'd2300000;
	localparam logic [TIME_W-1:0] T_2_6 = 32'd2600000;
	localparam logic [TIME_W-1:0] T_3_0 = 32'd3000000;
	localparam logic [TIME_W-1:0] T_3_4 = 32'd3400000;
	localparam logic [TIME_W-1:0] T_3_5 = 32'd3500000;
	localparam logic [TIME_W-1:0] T_3_6 = 32'd3600000;
	localparam logic [TIME_W-1:0] T_4_1 = 32'd4100000;
	localparam logic [TIME_W-1:0] T_5_6 = 32'd5600000;

endpackage

[src/etvs_if.sv]
interface etvs_tick_if import etvs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [TICK_W-1:0] tick_us;

	modport source (output valid, command, tick_us, input ready);
	modport sink (input valid, command, tick_us, output ready);
endinterface

interface etvs_result_if import etvs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [NVALVE-1:0] valves;
	logic              spark_on;
	logic              tvc_test_active;
	logic [TIME_W-1:0] sequence_time_us;
	logic              tvc_stop;
	logic [2:0]        mode;

	modport source (output valid, valves, spark_on, tvc_test_active, sequence_time_us,
		tvc_stop, mode, input ready);
	modport sink (input valid, valves, spark_on, tvc_test_active, sequence_time_us,
		tvc_stop, mode, output ready);
endinterface

[src/engine_test_valve_sequencer.sv]
// Engine test valve sequencer. One command beat per control tick carries a command code and
// the microseconds since the previous tick; each beat yields exactly one result beat with the
// valve bits, spark, thrust vector test/stop outputs and mode after that tick. A beat is taken
// in every cycle the result register is free or being drained, and its result appears in the
// next cycle; the whole tick update (saturating 32-bit elapsed-time add, window compares,
// valve/spark/mode update) completes in the accepting cycle. Reset enters hotfire idle with
// all valves closed and the spark off. An abort from hotfire idle takes one more tick to
// vent through the bleed and then locks the block in the terminated mode until reset.
`include "assert_macros.svh"

module engine_test_valve_sequencer import etvs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	etvs_tick_if.sink     tick,
	etvs_result_if.source result
);

	mode_t             mode_q, mode_d;
	logic [TIME_W-1:0] elapsed_q, elapsed_d;
	logic              started_q, started_d;
	logic [NSTEP-1:0]  flags_q, flags_d;
	logic [NVALVE-1:0] valve_q, valve_d;
	logic              spark_q, spark_d;

	logic              active_d, stop_d;
	logic [TIME_W-1:0] ttime_d;
	logic [TIME_W:0]   sum;
	logic [CMD_W-1:0]  cm1;
	logic              finished;
	logic              accept;

	logic              out_valid_q;
	logic [NVALVE-1:0] res_valves_q;
	logic              res_spark_q;
	logic              res_active_q;
	logic [TIME_W-1:0] res_time_q;
	logic              res_stop_q;
	mode_t             res_mode_q;

	assign tick.ready = !out_valid_q || result.ready;
	assign accept     = tick.valid && tick.ready;

	always_comb begin
		mode_d    = mode_q;
		elapsed_d = elapsed_q;
		started_d = started_q;
		flags_d   = flags_q;
		valve_d   = valve_q;
		spark_d   = spark_q;
		active_d  = 1'b0;
		stop_d    = 1'b0;
		ttime_d   = '0;
		finished  = 1'b0;
		cm1       = tick.command - CMD_VALVE_FIRST;
		sum       = {1'b0, elapsed_q} + {{(TIME_W + 1 - TICK_W){1'b0}}, tick.tick_us};

		// manual commands
		if (mode_q != MODE_TERM) begin
			if (tick.command >= CMD_VALVE_FIRST && tick.command <= CMD_VALVE_LAST) begin
				valve_d[cm1[3:1]] = !cm1[0];
			end else if (tick.command == CMD_SPARK_ON) begin
				spark_d = 1'b1;
			end else if (tick.command == CMD_SPARK_OFF) begin
				spark_d = 1'b0;
			end
		end

		// sequence clock
		if (mode_q == MODE_IGN || mode_q == MODE_WATER || mode_q == MODE_HOT) begin
			if (!started_q) begin
				started_d = 1'b1;
				elapsed_d = '0;
				if (mode_q == MODE_WATER) begin
					valve_d = valve_d | V_MAIN_N2O;
				end else begin
					valve_d = valve_d | V_IGN_OX;
					spark_d = 1'b1;
				end
			end else begin
				elapsed_d = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
			end
		end

		unique case (mode_q)
			MODE_IDLE: begin
				if (tick.command == CMD_ABORT) begin
					mode_d = MODE_ABORT;
				end else if (tick.command == CMD_STANDBY || tick.command == CMD_IDLE) begin
					mode_d = MODE_REL;
				end else if (tick.command == CMD_IGN_TEST) begin
					mode_d = MODE_IGN;
				end else if (tick.command == CMD_WATER) begin
					mode_d = MODE_WATER;
				end else if (tick.command == CMD_HOTFIRE) begin
					mode_d = MODE_HOT;
				end
			end
			MODE_IGN: begin
				if (elapsed_d >= T_0_3 && elapsed_d < T_2_3) begin
					if (!flags_d[0]) begin
						flags_d[0] = 1'b1;
						valve_d    = valve_d | V_IGN_ETH;
					end
				end else if (elapsed_d >= T_2_3 && elapsed_d < T_2_6) begin
					if (!flags_d[1]) begin
						flags_d[1] = 1'b1;
						valve_d    = valve_d & ~V_IGN_ETH;
						spark_d    = 1'b0;
					end
				end else if (elapsed_d >= T_2_6) begin
					if (!flags_d[2]) begin
						flags_d[2] = 1'b1;
						valve_d    = valve_d & ~V_IGN_OX;
					end
					if (elapsed_d >= T_3_0) begin
						finished = 1'b1;
					end
				end
				if (finished) begin
					started_d = 1'b0;
					flags_d   = '0;
					mode_d    = MODE_IDLE;
				end else if (tick.command == CMD_ABORT) begin
					valve_d   = valve_d & ~(V_IGN_OX | V_IGN_ETH);
					spark_d   = 1'b0;
					started_d = 1'b0;
					flags_d   = '0;
					mode_d    = MODE_IDLE;
				end
			end
			MODE_WATER: begin
				if (elapsed_d >= T_1_0 && elapsed_d < T_2_0) begin
					if (!flags_d[0]) begin
						flags_d[0] = 1'b1;
						valve_d    = valve_d | V_MAIN_ETH;
					end
				end else if (elapsed_d >= T_3_0) begin
					if (!flags_d[1]) begin
						flags_d[1] = 1'b1;
						valve_d    = valve_d & ~(V_MAIN_N2O | V_MAIN_ETH);
					end
					if (elapsed_d >= T_3_5) begin
						finished = 1'b1;
					end
				end
				if (finished) begin
					started_d = 1'b0;
					flags_d   = '0;
					mode_d    = MODE_IDLE;
				end else if (tick.command == CMD_ABORT) begin
					valve_d   = valve_d & ~(V_MAIN_N2O | V_MAIN_ETH);
					started_d = 1'b0;
					flags_d   = '0;
					mode_d    = MODE_IDLE;
				end
			end
			MODE_HOT: begin
				if (elapsed_d >= T_0_2 && elapsed_d < T_0_5) begin
					if (!flags_d[0]) begin
						flags_d[0] = 1'b1;
						valve_d    = valve_d | V_IGN_ETH;
					end
				end else if (elapsed_d >= T_0_5 && elapsed_d < T_0_7) begin
					if (!flags_d[1]) begin
						flags_d[1] = 1'b1;
						valve_d    = valve_d | V_MAIN_N2O | V_MAIN_ETH;
					end
				end else if (elapsed_d >= T_0_7 && elapsed_d < T_3_4) begin
					if (!flags_d[2]) begin
						flags_d[2] = 1'b1;
						spark_d    = 1'b0;
						valve_d    = valve_d & ~V_IGN_OX;
					end
					active_d = 1'b1;
					ttime_d  = elapsed_d;
				end else if (elapsed_d >= T_3_4 && elapsed_d < T_3_6) begin
					if (!flags_d[3]) begin
						flags_d[3] = 1'b1;
						stop_d     = 1'b1;
						valve_d    = valve_d & ~(V_IGN_ETH | V_MAIN_ETH);
					end
				end else if (elapsed_d >= T_3_6 && elapsed_d < T_4_1) begin
					if (!flags_d[4]) begin
						flags_d[4] = 1'b1;
						valve_d    = valve_d & ~V_MAIN_N2O;
					end
				end else if (elapsed_d >= T_4_1 && elapsed_d < T_5_6) begin
					if (!flags_d[5]) begin
						flags_d[5] = 1'b1;
						valve_d    = valve_d | V_PURGE;
					end
				end else if (elapsed_d >= T_5_6) begin
					finished = 1'b1;
				end
				if (finished) begin
					valve_d   = valve_d & ~V_PURGE;
					started_d = 1'b0;
					flags_d   = '0;
					mode_d    = MODE_IDLE;
				end else if (tick.command == CMD_ABORT) begin
					spark_d   = 1'b0;
					valve_d   = valve_d & ~(V_IGN_ETH | V_MAIN_ETH | V_MAIN_N2O | V_PURGE);
					stop_d    = 1'b1;
					started_d = 1'b0;
					flags_d   = '0;
					mode_d    = MODE_IDLE;
				end
			end
			MODE_ABORT: begin
				stop_d  = 1'b1;
				valve_d = V_BLEED;
				spark_d = 1'b0;
				mode_d  = MODE_TERM;
			end
			MODE_TERM: begin
			end
			default: begin
				if (tick.command == CMD_HOT_IDLE) begin
					mode_d = MODE_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			elapsed_q   <= '0;
			started_q   <= 1'b0;
			flags_q     <= '0;
			valve_q     <= '0;
			spark_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q    <= mode_d;
				elapsed_q <= elapsed_d;
				started_q <= started_d;
				flags_q   <= flags_d;
				valve_q   <= valve_d;
				spark_q   <= spark_d;
			end
			if (tick.ready) begin
				out_valid_q <= tick.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_valves_q <= valve_d;
			res_spark_q  <= spark_d;
			res_active_q <= active_d;
			res_time_q   <= ttime_d;
			res_stop_q   <= stop_d;
			res_mode_q   <= mode_d;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.valves           = res_valves_q;
	assign result.spark_on         = res_spark_q;
	assign result.tvc_test_active  = res_active_q;
	assign result.sequence_time_us = res_time_q;
	assign result.tvc_stop         = res_stop_q;
	assign result.mode             = res_mode_q;

	`AST_ALWAYS(a_tvc_window, clk, arst_n,
		!(out_valid_q && res_active_q) || (res_time_q >= T_0_7 && res_time_q < T_3_4),
		"thrust vector test outside its window")
	`AST_ALWAYS(a_time_gated, clk, arst_n,
		!out_valid_q || res_active_q || (res_time_q == '0),
		"sequence time without thrust vector test")
	`AST_ALWAYS(a_idle_clean, clk, arst_n,
		(mode_q != MODE_IDLE) || ((flags_q == '0) && !started_q),
		"sequence flags left set in idle")
	`AST_NEXT(a_term_sticky, clk, arst_n, mode_q == MODE_TERM,
		(mode_q == MODE_TERM) && (valve_q == V_BLEED) && !spark_q,
		"terminated state left")

endmodule
